[rtl/core/pgcs_pkg.sv]
package pgcs_pkg;

  localparam int MaxCornersDefault = 64;
  localparam int MaxCellsDefault = 4096;
  localparam int CoordW = 24;
  localparam int SideW = 23;
  localparam int IdxW = 12;
  localparam logic signed [CoordW-1:0] BoxStart = 24'sd256000;
  localparam logic [SideW-1:0] CellSideReset = 23'd1280;
  localparam logic [SideW-1:0] AreaSideReset = 23'd256000;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    REG_CELL_SIDE = 1'b0,
    REG_AREA_SIDE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] mode;
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic signed [CoordW-1:0] vertex_z;
    logic [IdxW-1:0] cell_col;
    logic [IdxW-1:0] cell_row;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic overflowed;
  } out_item_t;

  // Classified command between front and back
  typedef struct packed {
    logic [1:0] mode;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [IdxW-1:0] col;
    logic [IdxW-1:0] row;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CENTER,
    ST_EDGE_RD,
    ST_EDGE_MUL,
    ST_EDGE_CMP,
    ST_OUT
  } bk_state_t;

endpackage

[rtl/core/pgcs_queue.sv]
module pgcs_queue #(
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  pgcs_pkg::cmd_t   wr_data,
  output logic             full,
  input  logic             rd_en,
  output pgcs_pkg::cmd_t   rd_data,
  output logic             not_empty
);
  import pgcs_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0] count;

  assign full = (count == (PtrW+1)'(Depth));
  assign not_empty = (count != '0);
  assign rd_data = mem[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

[rtl/core/pgcs_front.sv]
module pgcs_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  pgcs_pkg::in_item_t in_data,
  output logic               q_wr,
  output pgcs_pkg::cmd_t     q_data,
  input  logic               q_full
);
  import pgcs_pkg::*;

  logic keep;

  // Drop unused mode codes, pass the rest on
  assign keep = (in_data.mode != MODE_NONE);
  assign in_stall = q_full;
  assign q_wr = in_valid && !q_full && keep;

  always_comb begin
    q_data.mode = in_data.mode;
    q_data.x = in_data.vertex_x;
    q_data.y = in_data.vertex_y;
    q_data.z = in_data.vertex_z;
    q_data.col = in_data.cell_col;
    q_data.row = in_data.cell_row;
  end

endmodule

[rtl/core/pgcs_back.sv]
module pgcs_back #(
  parameter int MaxCorners = pgcs_pkg::MaxCornersDefault,
  parameter int MaxCells = pgcs_pkg::MaxCellsDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [pgcs_pkg::SideW-1:0] cell_side,
  input  logic [pgcs_pkg::SideW-1:0] area_side,
  input  logic                     q_valid,
  input  pgcs_pkg::cmd_t           q_data,
  output logic                     q_rd,
  output logic                     out_valid,
  input  logic                     out_stall,
  output pgcs_pkg::out_item_t      out_data
);
  import pgcs_pkg::*;

  localparam int AddrW = $clog2(MaxCorners);
  localparam int CntW = $clog2(MaxCorners + 1);
  localparam int CellW = $clog2(MaxCells + 1);
  localparam int HalfW = 40;   // half-unit centre width
  localparam int DW = 27;      // doubled coordinate differences
  localparam int PW = 2 * DW;

  bk_state_t state, state_next;

  logic signed [CoordW-1:0] cx_mem [MaxCorners];
  logic signed [CoordW-1:0] cy_mem [MaxCorners];
  logic [CntW-1:0] corner_count;
  logic signed [CoordW-1:0] first_height;
  logic signed [CoordW-1:0] box_min_x, box_min_y, box_max_x, box_max_y;
  logic dropped_flag;

  cmd_t cmd;
  // Quotient area_side / cell_side, restoring, one bit a cycle
  logic [SideW-1:0] div_rem;
  logic [SideW-1:0] div_q;
  logic [4:0] div_bit;
  logic signed [HalfW-1:0] hx, hy;
  logic in_range;

  // Edge walk
  logic [AddrW-1:0] ei, ej;
  logic [CntW-1:0] edges_left;
  logic signed [CoordW-1:0] rd_xi, rd_yi, rd_xj, rd_yj;
  logic signed [DW-1:0] d, a, b, c;
  logic straddle;
  logic signed [PW-1:0] lhs, rhs;
  logic mul_straddle, mul_dpos;
  logic odd;
  logic box_ok;

  logic take;
  assign q_rd = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the command
  always_comb begin
    state_next = state;
    take = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid && !out_valid) begin
          take = 1'b1;
          if (q_data.mode == MODE_QUERY) begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_bit == 5'd0) begin
          state_next = ST_CENTER;
        end
      end
      ST_CENTER: begin
        if (box_ok && in_range && corner_count != '0) begin
          state_next = ST_EDGE_RD;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_EDGE_RD: state_next = ST_EDGE_MUL;
      ST_EDGE_MUL: state_next = ST_EDGE_CMP;
      ST_EDGE_CMP: begin
        state_next = (edges_left == CntW'(1)) ? ST_OUT : ST_EDGE_RD;
      end
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Clear and append polygon state
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= '0;
      first_height <= '0;
      dropped_flag <= 1'b0;
      box_min_x <= BoxStart;
      box_min_y <= BoxStart;
      box_max_x <= -BoxStart;
      box_max_y <= -BoxStart;
    end else if (take && q_data.mode == MODE_CLEAR) begin
      corner_count <= '0;
      first_height <= '0;
      dropped_flag <= 1'b0;
      box_min_x <= BoxStart;
      box_min_y <= BoxStart;
      box_max_x <= -BoxStart;
      box_max_y <= -BoxStart;
    end else if (take && q_data.mode == MODE_APPEND) begin
      if (corner_count >= CntW'(MaxCorners)) begin
        dropped_flag <= 1'b1;
      end else begin
        if (corner_count == '0) begin
          first_height <= q_data.z;
        end
        corner_count <= corner_count + 1'b1;
        if (q_data.x < box_min_x) box_min_x <= q_data.x;
        if (q_data.y < box_min_y) box_min_y <= q_data.y;
        if (q_data.x > box_max_x) box_max_x <= q_data.x;
        if (q_data.y > box_max_y) box_max_y <= q_data.y;
      end
    end
  end

  // Vertex memories, read address chosen each edge step
  always_ff @(posedge clk) begin
    if (take && q_data.mode == MODE_APPEND && corner_count < CntW'(MaxCorners)) begin
      cx_mem[corner_count[AddrW-1:0]] <= q_data.x;
      cy_mem[corner_count[AddrW-1:0]] <= q_data.y;
    end
  end

  always_ff @(posedge clk) begin
    rd_xi <= cx_mem[ei];
    rd_yi <= cy_mem[ei];
  end

  always_ff @(posedge clk) begin
    rd_xj <= cx_mem[ej];
    rd_yj <= cy_mem[ej];
  end

  // Divider and centre
  logic [SideW:0] div_trial;
  logic [CellW-1:0] cells;
  logic [HalfW-1:0] span_x, span_y;

  assign div_trial = {div_rem, area_side[div_bit]} - {1'b0, cell_side};

  always_comb begin
    if (cell_side == '0) begin
      cells = '0;
    end else if ({1'b0, div_q} > (SideW+1)'(MaxCells)) begin
      cells = CellW'(MaxCells);
    end else begin
      cells = CellW'(div_q);
    end
    span_x = HalfW'({1'b0, cmd.col, 1'b0}) * HalfW'(cell_side);
    span_y = HalfW'({1'b0, cmd.row, 1'b0}) * HalfW'(cell_side);
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= q_data;
      div_rem <= '0;
      div_q <= '0;
      div_bit <= 5'(SideW - 1);
    end else if (state == ST_DIV) begin
      if (!div_trial[SideW]) begin
        div_rem <= div_trial[SideW-1:0];
        div_q <= {div_q[SideW-2:0], 1'b1};
      end else begin
        div_rem <= {div_rem[SideW-2:0], area_side[div_bit]};
        div_q <= {div_q[SideW-2:0], 1'b0};
      end
      if (div_bit != 5'd0) div_bit <= div_bit - 1'b1;
      hx <= $signed(span_x + HalfW'(cell_side)) - $signed(HalfW'(area_side));
      hy <= $signed(span_y + HalfW'(cell_side)) - $signed(HalfW'(area_side));
    end
  end

  always_comb begin
    in_range = ({{(CellW > IdxW ? CellW-IdxW : 1){1'b0}}, cmd.col} < CellW'(cells) ||
                1'b0) &&
               ({{(CellW > IdxW ? CellW-IdxW : 1){1'b0}}, cmd.row} < CellW'(cells));
    box_ok = (hx > HalfW'(2 * box_min_x)) && (hy > HalfW'(2 * box_min_y)) &&
             (hx < HalfW'(2 * box_max_x)) && (hy < HalfW'(2 * box_max_y));
  end

  // Edge operands: doubled vertices against half-unit centre
  logic signed [HalfW-1:0] pyx, pyy;
  always_comb begin
    pyx = hx;
    pyy = hy;
    d = DW'(2 * rd_yj) - DW'(2 * rd_yi);
    a = DW'(pyx - HalfW'(2 * rd_xi));
    b = DW'(2 * rd_xj) - DW'(2 * rd_xi);
    c = DW'(pyy - HalfW'(2 * rd_yi));
    straddle = (HalfW'(2 * rd_yi) > pyy) != (HalfW'(2 * rd_yj) > pyy);
  end

  // Walk edges: multiply, then compare
  always_ff @(posedge clk) begin
    if (state == ST_CENTER) begin
      ei <= '0;
      ej <= AddrW'(corner_count - 1'b1);
      edges_left <= corner_count;
      odd <= 1'b0;
    end else if (state == ST_EDGE_MUL) begin
      lhs <= a * d;
      rhs <= b * c;
      mul_straddle <= straddle;
      mul_dpos <= (d > 0);
    end else if (state == ST_EDGE_CMP) begin
      if (mul_straddle && (mul_dpos ? (lhs < rhs) : (lhs > rhs))) begin
        odd <= !odd;
      end
      ej <= ei;
      ei <= ei + 1'b1;
      edges_left <= edges_left - 1'b1;
    end else if (take) begin
      odd <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT) begin
      out_data.inside_res <= odd;
      out_data.center_x <= CoordW'(hx >>> 1);
      out_data.center_y <= CoordW'(hy >>> 1);
      out_data.center_z <= first_height;
      out_data.overflowed <= dropped_flag;
    end
  end

endmodule

[rtl/core/polygon_grid_cell_select.sv]
// Polygon grid cell selector.
// Input channel (in_valid/in_stall/in_data): mode 0 clears the polygon,
// mode 1 appends a vertex, mode 2 queries one grid cell; mode 3 is dropped.
// Output channel (out_valid/out_stall/out_data): one item per query with
// the inside flag, the cell centre, the first vertex height and the
// overflow flag. Clear and append give no output item.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) sets cell_side
// (index 0) and area_side (index 1); write only while idle.
// A two-entry queue decouples the input side from the executing back end.
// Clear and append are handled in the idle state of the back end. A query
// runs the divider, a set-up step, then, for a cell in range and inside the
// box of a non-empty polygon, the vertex memory read, the multiplier stage
// and the compare for each edge, and an output step.
// The back end holds while a result is waiting in the output register;
// a stalled output item stays unchanged, and the queue then fills and
// raises in_stall. Reset empties the polygon, resets the box and the
// registers to 1280 and 256000, and drops any queued item.
module polygon_grid_cell_select #(
  parameter int MaxCorners = pgcs_pkg::MaxCornersDefault,
  parameter int MaxCells = pgcs_pkg::MaxCellsDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pgcs_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pgcs_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [pgcs_pkg::SideW-1:0]  cfg_data
);
  import pgcs_pkg::*;

  logic [SideW-1:0] cell_side, area_side;
  logic q_wr, q_full, q_rd, q_ne;
  cmd_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_side <= CellSideReset;
      area_side <= AreaSideReset;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_CELL_SIDE: cell_side <= cfg_data;
        REG_AREA_SIDE: area_side <= cfg_data;
        default: ;
      endcase
    end
  end

  pgcs_front u_front (
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_wr(q_wr), .q_data(q_wdata), .q_full(q_full)
  );

  pgcs_queue #(.Depth(2)) u_queue (
    .clk(clk), .rst(rst),
    .wr_en(q_wr), .wr_data(q_wdata), .full(q_full),
    .rd_en(q_rd), .rd_data(q_rdata), .not_empty(q_ne)
  );

  pgcs_back #(.MaxCorners(MaxCorners), .MaxCells(MaxCells)) u_back (
    .clk(clk), .rst(rst),
    .cell_side(cell_side), .area_side(area_side),
    .q_valid(q_ne), .q_data(q_rdata), .q_rd(q_rd),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pgcs_pkg::*;

  localparam int Corners = 64;
  localparam int CellsMax = 4096;
  localparam longint CycleLimit = 3000000;

  class cell_scoreboard;
    logic signed [23:0] vx[Corners];
    logic signed [23:0] vy[Corners];
    int unsigned count;
    logic signed [23:0] height;
    logic dropped;
    longint bminx, bminy, bmaxx, bmaxy;
    longint cside, area;
    out_item_t pending[$];
    int errors;
    int queries;
    int hits;

    function void clear_polygon();
      count = 0;
      height = 0;
      dropped = 0;
      bminx = 256000;
      bminy = 256000;
      bmaxx = -256000;
      bmaxy = -256000;
    endfunction

    function void set_reg(reg_idx_t idx, logic [22:0] val);
      if (idx == REG_CELL_SIDE) cside = val;
      else area = val;
    endfunction

    // even-odd crossing on doubled coordinates
    function bit odd_crossings(longint px, longint py);
      bit odd;
      longint xi, yi, xj, yj, d, lhs, rhs;
      int j;
      odd = 0;
      if (count == 0) return 0;
      j = count - 1;
      for (int i = 0; i < count; i++) begin
        xi = 2 * longint'(vx[i]);
        yi = 2 * longint'(vy[i]);
        xj = 2 * longint'(vx[j]);
        yj = 2 * longint'(vy[j]);
        if ((yi > py) != (yj > py)) begin
          d = yj - yi;
          lhs = (px - xi) * d;
          rhs = (xj - xi) * (py - yi);
          if ((d > 0) ? (lhs < rhs) : (lhs > rhs)) odd = !odd;
        end
        j = i;
      end
      return odd;
    endfunction

    function longint floor_half(longint h);
      return (h >= 0) ? h / 2 : -((1 - h) / 2);
    endfunction

    function void note_input(in_item_t it);
      longint cells, hx, hy;
      out_item_t res;
      case (mode_t'(it.mode))
        MODE_CLEAR: clear_polygon();
        MODE_APPEND: begin
          if (count >= Corners) begin
            dropped = 1;
          end else begin
            if (count == 0) height = it.vertex_z;
            vx[count] = it.vertex_x;
            vy[count] = it.vertex_y;
            count++;
            if (it.vertex_x < bminx) bminx = it.vertex_x;
            if (it.vertex_y < bminy) bminy = it.vertex_y;
            if (it.vertex_x > bmaxx) bmaxx = it.vertex_x;
            if (it.vertex_y > bmaxy) bmaxy = it.vertex_y;
          end
        end
        MODE_QUERY: begin
          cells = (cside == 0) ? 0 : area / cside;
          if (cells > CellsMax) cells = CellsMax;
          hx = 2 * longint'(it.cell_col) * cside + cside - area;
          hy = 2 * longint'(it.cell_row) * cside + cside - area;
          res = '0;
          if (it.cell_col < cells && it.cell_row < cells && hx > 2 * bminx &&
              hy > 2 * bminy && hx < 2 * bmaxx && hy < 2 * bmaxy)
            res.inside_res = odd_crossings(hx, hy);
          res.center_x = floor_half(hx);
          res.center_y = floor_half(hy);
          res.center_z = height;
          res.overflowed = dropped;
          pending = {pending, res};
        end
        default: ;
      endcase
    endfunction

    function void report(string what);
      $display("mismatch: %s", what);
      errors++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      want = pending.pop_front();
      queries++;
      if (got.inside_res) hits++;
      if (got.inside_res !== want.inside_res)
        report($sformatf("inside got %b want %b", got.inside_res, want.inside_res));
      if (got.center_x !== want.center_x)
        report($sformatf("center_x got %0d want %0d", got.center_x, want.center_x));
      if (got.center_y !== want.center_y)
        report($sformatf("center_y got %0d want %0d", got.center_y, want.center_y));
      if (got.center_z !== want.center_z)
        report($sformatf("center_z got %0d want %0d", got.center_z, want.center_z));
      if (got.overflowed !== want.overflowed)
        report($sformatf("overflowed got %b want %b", got.overflowed, want.overflowed));
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = 0;
  logic [SideW-1:0] cfg_data = '0;

  cell_scoreboard board;
  longint cycles = 0;
  bit calm = 0;
  int unsigned sent = 0;

  polygon_grid_cell_select u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // check results and stall the output in bursts
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) board.check_result(out_data);
      if (burst > 0) begin
        burst--;
        out_stall <= 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 16) - 1;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic send(in_item_t it);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(it);
    sent++;
  endtask

  task automatic idle_out();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [SideW-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    board.set_reg(idx, val);
  endtask

  function automatic in_item_t make_item(mode_t m, int x, int y, int z, int c, int r);
    in_item_t it;
    it = '0;
    it.mode = m;
    it.vertex_x = x;
    it.vertex_y = y;
    it.vertex_z = z;
    it.cell_col = c;
    it.cell_row = r;
    return it;
  endfunction

  function automatic in_item_t rand_item(mode_t m);
    return make_item(m, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // polygon scaled to the area with random vertex count
  task automatic load_polygon(int n, int span);
    send(make_item(MODE_CLEAR, 0, 0, 0, 0, 0));
    for (int i = 0; i < n; i++)
      send(make_item(MODE_APPEND, $urandom_range(0, 2 * span) - span,
                     $urandom_range(0, 2 * span) - span, $urandom, 0, 0));
  endtask

  task automatic query_burst(int n, int cells);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send(rand_item(MODE_QUERY));
      else send(make_item(MODE_QUERY, $urandom, $urandom, $urandom,
                          $urandom_range(0, cells), $urandom_range(0, cells)));
    end
  endtask

  initial begin
    int cells;
    int span;
    board = new();
    board.clear_polygon();
    board.set_reg(REG_CELL_SIDE, CellSideReset);
    board.set_reg(REG_AREA_SIDE, AreaSideReset);
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty polygon, square, extremes, overflow, unused mode
    send(make_item(MODE_QUERY, 0, 0, 0, 100, 100));
    send(make_item(MODE_APPEND, -100000, -100000, -8388608, 0, 0));
    send(make_item(MODE_APPEND, 100000, -100000, 8388607, 0, 0));
    send(make_item(MODE_APPEND, 100000, 100000, 5, 0, 0));
    send(make_item(MODE_APPEND, -100000, 100000, 5, 0, 0));
    send(make_item(MODE_QUERY, 0, 0, 0, 100, 100));
    send(make_item(MODE_QUERY, 0, 0, 0, 0, 0));
    send(make_item(MODE_QUERY, 0, 0, 0, 199, 199));
    send(make_item(MODE_QUERY, 0, 0, 0, 200, 3));
    send(make_item(MODE_QUERY, 0, 0, 0, 4095, 4095));
    send(make_item(MODE_NONE, 1, 1, 1, 1, 1));
    send(make_item(MODE_APPEND, 8388607, -8388608, 0, 0, 0));
    send(make_item(MODE_APPEND, -8388608, 8388607, 0, 0, 0));
    for (int i = 0; i < 62; i++) send(rand_item(MODE_APPEND));
    send(make_item(MODE_QUERY, 0, 0, 0, 77, 120));
    send(make_item(MODE_CLEAR, 0, 0, 0, 0, 0));
    send(make_item(MODE_QUERY, 0, 0, 0, 5, 5));
    idle_out();

    // extreme and random settings, each with polygons and queries
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin write_reg(REG_CELL_SIDE, 0); write_reg(REG_AREA_SIDE, 4194304); end
        1: begin write_reg(REG_CELL_SIDE, 1); write_reg(REG_AREA_SIDE, 4194304); end
        2: begin write_reg(REG_CELL_SIDE, 4194304); write_reg(REG_AREA_SIDE, 1); end
        3: begin write_reg(REG_CELL_SIDE, 8388607); write_reg(REG_AREA_SIDE, 8388607); end
        4: begin write_reg(REG_CELL_SIDE, 1); write_reg(REG_AREA_SIDE, 0); end
        default: begin
          write_reg(REG_CELL_SIDE, $urandom_range(1, 40000));
          write_reg(REG_AREA_SIDE, $urandom_range(1, 4194304));
        end
      endcase
      if (phase == 9) begin
        write_reg(REG_CELL_SIDE, CellSideReset);
        write_reg(REG_AREA_SIDE, AreaSideReset);
      end
      cells = (board.cside == 0) ? 8 : board.area / board.cside;
      if (cells > 4095) cells = 4095;
      span = (board.area / 2) + 1;
      if (span > 8388607) span = 8388607;
      for (int p = 0; p < 6; p++) begin
        if (phase == 9 && p == 3) calm = 1;
        load_polygon(($urandom_range(0, 5) == 0) ? $urandom_range(0, 70)
                                                 : $urandom_range(3, 10), span);
        if ($urandom_range(0, 3) == 0) send(rand_item(mode_t'($urandom_range(0, 3))));
        query_burst(12, cells);
      end
      idle_out();
    end

    $display("sent %0d items, checked %0d cell queries, %0d inside",
             sent, board.queries, board.hits);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[files.f]
rtl/core/pgcs_pkg.sv
rtl/core/pgcs_queue.sv
rtl/core/pgcs_front.sv
rtl/core/pgcs_back.sv
rtl/core/polygon_grid_cell_select.sv
tb/testbench.sv
